### rtl/core/bsa_pkg.sv
package bsa_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = 9;
  localparam int BYTES_W   = 16;
  localparam int OFS_W     = 24;
  localparam int ROW_W     = 32;
  localparam int BIT_W     = $clog2(ROW_W);
  localparam int ROWS      = MAX_SLOTS / ROW_W;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 1'd1;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot_index;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [OFS_W-1:0]    byte_offset;
  } out_word_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
  } bsa_mem_req_t;

endpackage

### rtl/core/bsa_bitmap_mem.sv
module bsa_bitmap_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bsa_pkg::bsa_mem_req_t      req,
  output logic [bsa_pkg::ROW_W-1:0]  rd_data
);
  import bsa_pkg::*;

  logic [ROW_W-1:0] mem_r [ROWS];
  logic [ROWS-1:0]  row_vld_r;
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  // rows never written read as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/core/bsa_find.sv
module bsa_find (
  input  logic [bsa_pkg::ROW_W-1:0]  row_data,
  input  logic [bsa_pkg::ROW_AW-1:0] row,
  input  logic [bsa_pkg::CNT_W-1:0]  lo,
  input  logic [bsa_pkg::CNT_W-1:0]  hi,
  output logic                       found,
  output logic [bsa_pkg::BIT_W-1:0]  bit_sel
);
  import bsa_pkg::*;

  logic [ROW_W-1:0] avail;

  always_comb begin
    logic [CNT_W-1:0] g;
    for (int b = 0; b < ROW_W; b++) begin
      g = {{(CNT_W-SLOT_W){1'b0}}, row, BIT_W'(b)};
      avail[b] = !row_data[b] && (g >= lo) && (g < hi);
    end
  end

  // lowest free bit wins
  always_comb begin
    bit_sel = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        bit_sel = BIT_W'(b);
      end
    end
  end

  assign found = |avail;

endmodule

### rtl/core/bitmap_slot_allocator.sv
// Free in range: result follows the read and write-back of the slot's bitmap row; free out of
// range or allocate with zero slot count: result follows without any bitmap access.
// Allocate: result follows k bitmap rows read (1 to 9 of 32 slots each),
// one row per cycle through the single bitmap read port.
// Next word is taken the cycle after a result is loaded.
// Reset: pointer 0, slot_count 256, slot_bytes 1, per-row valid bits cleared.
module bitmap_slot_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bsa_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bsa_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsa_pkg::CFG_W-1:0]     cfg_wdata
);
  import bsa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    slot_count_r;
  logic [BYTES_W-1:0]  slot_bytes_r;
  logic [SLOT_W-1:0]   ptr_r, ptr_nxt;
  logic [ROW_AW-1:0]   row_r, row_nxt;
  logic                pass_r, pass_nxt;
  logic [SLOT_W-1:0]   pstart_r, pstart_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   grant_r, grant_nxt;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic [CNT_W-1:0]    n_eff;
  logic [CNT_W-1:0]    n_m1;
  logic [ROW_AW-1:0]   last_row;
  logic [SLOT_W-1:0]   p_eff;
  logic [CNT_W-1:0]    lo, hi;
  logic                found;
  logic [BIT_W-1:0]    fbit;
  logic [SLOT_W-1:0]   gi;
  logic [CNT_W-1:0]    gi_p1;
  logic [ROW_W-1:0]    rd_data;
  logic                in_acc;
  logic                out_load;
  bsa_mem_req_t        req;

  assign n_eff    = (slot_count_r > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_r;
  assign n_m1     = n_eff - CNT_W'(1);
  assign last_row = n_m1[SLOT_W-1:BIT_W];
  assign p_eff    = ({1'b0, ptr_r} >= n_eff) ? '0 : ptr_r;

  assign lo = pass_r ? '0 : {1'b0, pstart_r};
  assign hi = pass_r ? {1'b0, pstart_r} : n_eff;

  bsa_find u_find (
    .row_data (rd_data),
    .row      (row_r),
    .lo       (lo),
    .hi       (hi),
    .found    (found),
    .bit_sel  (fbit)
  );

  bsa_bitmap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign gi       = {row_r, fbit};
  assign gi_p1    = {1'b0, gi} + CNT_W'(1);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    row_nxt    = row_r;
    pass_nxt   = pass_r;
    pstart_nxt = pstart_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    grant_nxt  = grant_r;
    req        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          grant_nxt  = '0;
          status_nxt = ST_DONE;
          idx_nxt    = in_word.slot_index;
          if (in_word.mode == MODE_ALLOC) begin
            if (n_eff == '0) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              pstart_nxt  = p_eff;
              pass_nxt    = 1'b0;
              row_nxt     = p_eff[SLOT_W-1:BIT_W];
              req.rd_en   = 1'b1;
              req.rd_addr = p_eff[SLOT_W-1:BIT_W];
              state_nxt   = S_SCAN;
            end
          end else begin
            if ({1'b0, in_word.slot_index} >= n_eff) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = in_word.slot_index[SLOT_W-1:BIT_W];
              state_nxt   = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          req.wr_en   = 1'b1;
          req.wr_addr = row_r;
          req.wr_data = rd_data | (ROW_W'(1) << fbit);
          grant_nxt   = gi;
          ptr_nxt     = (gi_p1 >= n_eff) ? '0 : gi_p1[SLOT_W-1:0];
          state_nxt   = S_DONE;
        end else if (!pass_r && row_r == last_row) begin
          if (pstart_r == '0) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            pass_nxt    = 1'b1;
            row_nxt     = '0;
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
          end
        end else if (pass_r && row_r == pstart_r[SLOT_W-1:BIT_W]) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          row_nxt     = row_r + ROW_AW'(1);
          req.rd_en   = 1'b1;
          req.rd_addr = row_r + ROW_AW'(1);
        end
      end
      S_FREE: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_r[SLOT_W-1:BIT_W];
        req.wr_data = rd_data & ~(ROW_W'(1) << idx_r[BIT_W-1:0]);
        if (idx_r < ptr_r) begin
          ptr_nxt = idx_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ptr_r        <= '0;
      slot_count_r <= CNT_W'(256);
      slot_bytes_r <= BYTES_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOT_COUNT: slot_count_r <= cfg_wdata[CNT_W-1:0];
          REG_SLOT_BYTES: slot_bytes_r <= cfg_wdata[BYTES_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    pass_r   <= pass_nxt;
    pstart_r <= pstart_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
    if (out_load) begin
      out_word_r.status       <= status_r;
      out_word_r.granted_slot <= grant_r;
      out_word_r.byte_offset  <= OFS_W'(grant_r) * OFS_W'(slot_bytes_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.wr_en && req.rd_en))
    else $error("bitmap read and write in the same cycle");

  a_grant_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r != ST_DONE) |-> grant_r == '0)
    else $error("nonzero grant on failed request");

  a_scan_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> row_r <= last_row)
    else $error("scan row beyond slot count");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

endmodule

### tb/bitmap_slot_allocator_checker.sv
`timescale 1ns / 1ps

module bitmap_slot_allocator_checker
  import bsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   pending_count
);

  bit                 occupied [MAX_SLOTS];
  logic [SLOT_W-1:0]  next_fit;
  logic [CNT_W-1:0]   slot_count_q;
  logic [BYTES_W-1:0] slot_bytes_q;
  out_word_t          expected_results [$];

  function automatic int live_slots();
    int n;
    n = slot_count_q;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    if (n > 256) n = 256;
    return n;
  endfunction

  function automatic out_word_t serve_request(in_word_t req);
    out_word_t res;
    int        n;
    int        start;
    int        slot;
    bit        found;
    res   = '0;
    n     = live_slots();
    found = 1'b0;
    if (req.mode == MODE_ALLOC) begin
      start = (next_fit >= n) ? 0 : int'(next_fit);
      for (int k = 0; k < n && !found; k++) begin
        slot = start + k;
        if (slot >= n) slot -= n;
        if (!occupied[slot]) begin
          occupied[slot]   = 1'b1;
          found            = 1'b1;
          res.granted_slot = SLOT_W'(slot);
          res.byte_offset  = OFS_W'(slot * slot_bytes_q);
          next_fit         = (slot + 1 >= n) ? '0 : SLOT_W'(slot + 1);
        end
      end
      if (!found) res.status = ST_FULL;
    end else if (req.slot_index >= n) begin
      res.status = ST_RANGE;
    end else begin
      if (req.slot_index < next_fit) next_fit = req.slot_index;
      occupied[req.slot_index] = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      foreach (occupied[i]) occupied[i] = 1'b0;
      next_fit     = '0;
      slot_count_q = CNT_W'(256);
      slot_bytes_q = BYTES_W'(1);
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word: expected none, actual %p", $time, out_word);
        end else begin
          want = expected_results.pop_front();
          if (out_word.status !== want.status) begin
            mismatch_count++;
            $display("%0t: status: expected %0d, actual %0d",
                     $time, want.status, out_word.status);
          end
          if (out_word.granted_slot !== want.granted_slot) begin
            mismatch_count++;
            $display("%0t: granted_slot: expected %0d, actual %0d",
                     $time, want.granted_slot, out_word.granted_slot);
          end
          if (out_word.byte_offset !== want.byte_offset) begin
            mismatch_count++;
            $display("%0t: byte_offset: expected %0d, actual %0d",
                     $time, want.byte_offset, out_word.byte_offset);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_SLOT_COUNT) slot_count_q = cfg_wdata[CNT_W-1:0];
        else if (cfg_index == REG_SLOT_BYTES) slot_bytes_q = cfg_wdata[BYTES_W-1:0];
      end
      if (in_valid && !in_stall) expected_results.push_back(serve_request(in_word));
    end
    pending_count = expected_results.size();
  end

endmodule

### tb/bitmap_slot_allocator_tb.sv
`timescale 1ns / 1ps

module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatch_count;
  int                   pending_count;
  int                   send_idle_pct;
  int                   stall_pct;

  int count_table [12] = '{256, 1, 2, 37, 0, 16'hFFFF, 64, 5, 256, 33, 8, 100};
  int bytes_table [12] = '{65535, 1, 0, 300, 65535, 65535, -1, 7, 1, -1, 65535, 12345};
  int alloc_table [12] = '{60, 50, 50, 70, 50, 100, 40, 50, 30, 60, 50, 55};
  int len_table   [12] = '{110, 110, 110, 110, 40, 280, 110, 110, 110, 110, 110, 110};

  bitmap_slot_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bitmap_slot_allocator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic push_request(input logic op, input logic [SLOT_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{mode: op, slot_index: idx};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int               span;
    int               bytes;
    logic             op;
    logic [SLOT_W-1:0] idx;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_request(MODE_ALLOC, 8'd0);
    push_request(MODE_ALLOC, 8'd0);
    push_request(MODE_ALLOC, 8'd0);
    push_request(MODE_FREE, 8'd1);
    push_request(MODE_FREE, 8'd1);
    push_request(MODE_ALLOC, 8'd255);
    push_request(MODE_FREE, 8'd255);
    push_request(MODE_ALLOC, 8'd0);
    drain();
    write_reg(REG_SLOT_COUNT, CFG_W'(2));
    write_reg(REG_SLOT_BYTES, 16'hFFFF);
    push_request(MODE_ALLOC, 8'd0);
    push_request(MODE_FREE, 8'd1);
    push_request(MODE_ALLOC, 8'd0);
    push_request(MODE_FREE, 8'd255);
    push_request(MODE_ALLOC, 8'd0);
    drain();
    write_reg(REG_SLOT_COUNT, CFG_W'(0));
    write_reg(REG_SLOT_BYTES, CFG_W'(0));
    push_request(MODE_ALLOC, 8'd0);
    push_request(MODE_FREE, 8'd0);
    drain();
    write_reg(REG_SLOT_COUNT, CFG_W'(256));
    push_request(MODE_ALLOC, 8'd0);
    push_request(MODE_ALLOC, 8'd0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      bytes = (bytes_table[ph] < 0) ? int'($urandom_range(65535)) : bytes_table[ph];
      write_reg(REG_SLOT_COUNT, CFG_W'(count_table[ph]));
      write_reg(REG_SLOT_BYTES, CFG_W'(bytes));
      span = count_table[ph] & 9'h1FF;
      if (span > 256) span = 256;
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      repeat (len_table[ph]) begin
        op  = ($urandom_range(99) < alloc_table[ph]) ? MODE_ALLOC : MODE_FREE;
        idx = (span > 0 && $urandom_range(9) < 8) ? SLOT_W'($urandom_range(span - 1))
                                                 : SLOT_W'($urandom_range(255));
        push_request(op, idx);
      end
      drain();
      send_idle_pct = 0;
      stall_pct     = 0;
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### bitmap_slot_allocator.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_bitmap_mem.sv
rtl/core/bsa_find.sv
rtl/core/bitmap_slot_allocator.sv
tb/bitmap_slot_allocator_checker.sv
tb/bitmap_slot_allocator_tb.sv
